// ----- rtl/ntc_pkg.sv -----
// ----------------------------------------------------------------------------
// NTC Beta-equation temperature: shared package
// Widths, constants, codes and the command and status types that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ntc_pkg;

	// ADC resolution; full scale is 2^ADC_BITS - 1.
	localparam int ADC_BITS = 12;
	localparam int IN_W     = 12;
	localparam int CNT_W    = 9;
	localparam int SUM_W    = ADC_BITS + CNT_W;
	localparam logic [SUM_W-1:0] FULL = SUM_W'((1 << ADC_BITS) - 1);

	// Configuration register widths.
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 20;
	localparam int OHM_W     = 20;
	localparam int CENTI_W   = 15;
	localparam int BETA_W    = 14;

	// Log unit: operands, mantissa in Q30, fraction in Q24.
	localparam int LG_IN_W  = (SUM_W > OHM_W) ? SUM_W : OHM_W;
	localparam int P_W      = $clog2(LG_IN_W);
	localparam int LG_Q     = 30;
	localparam int M_W      = LG_Q + 1;
	localparam int FRAC_W   = 24;
	localparam int LG_ITERS = 24;
	localparam int LG_W     = P_W + FRAC_W;
	localparam int L_W      = LG_W + 2;
	localparam int MAG_W    = LG_W + 1;
	localparam int LN_W     = MAG_W;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;

	// Shared restoring divider. The divisor covers the largest inverse
	// temperature sum; the numerator covers ln magnitude scaled by 2^24.
	localparam int NUM_W       = LN_W + FRAC_W + 1;
	localparam int DEN_W       = 49;
	localparam int X_W         = DEN_W + 1;
	localparam int RECIP_SHIFT = 48;
	localparam int DIV_STEPS   = NUM_W;
	localparam int STEP_W      = $clog2(NUM_W);
	localparam int TC_W        = 16;
	localparam int BETA100_W   = 21;

	// Temperature constants in centi-degrees.
	localparam int TEMP_W       = 17;
	localparam int KELVIN_CENTI = 27315;
	localparam int TEMP_MAX     = 65535;
	localparam int TK_MAX       = TEMP_MAX + KELVIN_CENTI;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_ZERO = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SAMPLE_COUNT = 3'd0,
		CFG_SERIES_OHMS  = 3'd1,
		CFG_NOMINAL_OHMS = 3'd2,
		CFG_NOMINAL_TEMP = 3'd3,
		CFG_BETA         = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		DIV_TERM = 2'd0,
		DIV_INV0 = 2'd1,
		DIV_TK   = 2'd2
	} div_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_LG_LOAD,
		S_LG_ITER,
		S_LG_ACC,
		S_LN_MUL,
		S_TERM_LOAD,
		S_TERM_RUN,
		S_INV_LOAD,
		S_INV_RUN,
		S_X_CALC,
		S_TK_LOAD,
		S_TK_RUN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic       acc_en;
		logic       check;
		logic       lg_load;
		logic [1:0] lg_sel;
		logic       lg_step;
		logic       l_add;
		logic       ln_mul;
		logic       div_load;
		div_sel_t   div_sel;
		logic       div_step;
		logic       x_calc;
		logic       out_load;
	} ntc_cmd_t;

	typedef struct packed {
		logic round_full;
		logic special;
		logic x_nonpos;
	} ntc_stat_t;

endpackage

// ----- rtl/ntc_beta_temperature_core.sv -----
// Sequence: a sample that does not close a round is accepted, then passes a count check.
// A closing sample with an in-range sum then runs four log evaluations on the shared
// squaring unit, then up to three divisions on one restoring divider that retires a
// quotient bit per cycle. One result at a time.
// Reset: arst_n clears the controller, the accumulator and the output valid at once,
// and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
// NTC Beta-equation temperature core
// Averages ADC samples of a thermistor divider and converts them to a
// temperature in hundredths of a degree Celsius.
// ----------------------------------------------------------------------------
module ntc_beta_temperature_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ntc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ntc_pkg::CFG_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [ntc_pkg::IN_W-1:0]           adc_sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [ntc_pkg::TEMP_W-1:0]  temp_centi_c,
	output logic [1:0]                         status_code
);

	ntc_pkg::ntc_cmd_t  cmd;
	ntc_pkg::ntc_stat_t stat;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	ntc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	ntc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.adc_sample   (adc_sample),
		.cmd          (cmd),
		.stat         (stat),
		.temp_centi_c (temp_centi_c),
		.status_code  (status_code)
	);

endmodule

// ----- rtl/ntc_ctrl.sv -----
// ----------------------------------------------------------------------------
// NTC controller
// Sequences sample intake, the four log evaluations, the three divisions
// and the output transfer.
// ----------------------------------------------------------------------------
module ntc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  ntc_pkg::ntc_stat_t stat,
	output ntc_pkg::ntc_cmd_t  cmd
);

	ntc_pkg::state_t state_q, state_d;
	logic [1:0]                  op_q;
	logic [ntc_pkg::STEP_W-1:0]  step_q;
	logic                        out_valid_q;
	logic                        can_load;

	assign can_load = !out_valid_q || !out_stall;

	// State register and loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ntc_pkg::S_IDLE;
			op_q        <= 2'd0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ntc_pkg::S_CHECK:     op_q <= 2'd0;
				ntc_pkg::S_LG_ACC:    op_q <= op_q + 2'd1;
				default:              op_q <= op_q;
			endcase
			unique case (state_q)
				ntc_pkg::S_LG_ITER,
				ntc_pkg::S_TERM_RUN,
				ntc_pkg::S_INV_RUN,
				ntc_pkg::S_TK_RUN:    step_q <= step_q + 1'b1;
				default:              step_q <= '0;
			endcase
			out_valid_q <= cmd.out_load || (out_valid_q && out_stall);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ntc_pkg::S_IDLE:
				if (in_valid) state_d = ntc_pkg::S_CHECK;
			ntc_pkg::S_CHECK:
				if (!stat.round_full) state_d = ntc_pkg::S_IDLE;
				else if (stat.special) state_d = ntc_pkg::S_FINISH;
				else state_d = ntc_pkg::S_LG_LOAD;
			ntc_pkg::S_LG_LOAD:
				state_d = ntc_pkg::S_LG_ITER;
			ntc_pkg::S_LG_ITER:
				if (step_q == ntc_pkg::STEP_W'(ntc_pkg::LG_ITERS - 1))
					state_d = ntc_pkg::S_LG_ACC;
			ntc_pkg::S_LG_ACC:
				state_d = (op_q == 2'd3) ? ntc_pkg::S_LN_MUL : ntc_pkg::S_LG_LOAD;
			ntc_pkg::S_LN_MUL:
				state_d = ntc_pkg::S_TERM_LOAD;
			ntc_pkg::S_TERM_LOAD:
				state_d = ntc_pkg::S_TERM_RUN;
			ntc_pkg::S_TERM_RUN:
				if (step_q == ntc_pkg::STEP_W'(ntc_pkg::DIV_STEPS - 1))
					state_d = ntc_pkg::S_INV_LOAD;
			ntc_pkg::S_INV_LOAD:
				state_d = ntc_pkg::S_INV_RUN;
			ntc_pkg::S_INV_RUN:
				if (step_q == ntc_pkg::STEP_W'(ntc_pkg::DIV_STEPS - 1))
					state_d = ntc_pkg::S_X_CALC;
			ntc_pkg::S_X_CALC:
				state_d = stat.x_nonpos ? ntc_pkg::S_FINISH : ntc_pkg::S_TK_LOAD;
			ntc_pkg::S_TK_LOAD:
				state_d = ntc_pkg::S_TK_RUN;
			ntc_pkg::S_TK_RUN:
				if (step_q == ntc_pkg::STEP_W'(ntc_pkg::DIV_STEPS - 1))
					state_d = ntc_pkg::S_FINISH;
			ntc_pkg::S_FINISH:
				if (can_load) state_d = ntc_pkg::S_IDLE;
			default:
				state_d = ntc_pkg::S_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd          = '0;
		cmd.lg_sel   = op_q;
		cmd.div_sel  = ntc_pkg::DIV_TERM;
		unique case (state_q)
			ntc_pkg::S_IDLE:      cmd.acc_en = in_valid;
			ntc_pkg::S_CHECK:     cmd.check = 1'b1;
			ntc_pkg::S_LG_LOAD:   cmd.lg_load = 1'b1;
			ntc_pkg::S_LG_ITER:   cmd.lg_step = 1'b1;
			ntc_pkg::S_LG_ACC:    cmd.l_add = 1'b1;
			ntc_pkg::S_LN_MUL:    cmd.ln_mul = 1'b1;
			ntc_pkg::S_TERM_LOAD: cmd.div_load = 1'b1;
			ntc_pkg::S_INV_LOAD: begin
				cmd.div_load = 1'b1;
				cmd.div_sel  = ntc_pkg::DIV_INV0;
			end
			ntc_pkg::S_TK_LOAD: begin
				cmd.div_load = 1'b1;
				cmd.div_sel  = ntc_pkg::DIV_TK;
			end
			ntc_pkg::S_TERM_RUN,
			ntc_pkg::S_INV_RUN,
			ntc_pkg::S_TK_RUN:    cmd.div_step = 1'b1;
			ntc_pkg::S_X_CALC:    cmd.x_calc = 1'b1;
			ntc_pkg::S_FINISH:    cmd.out_load = can_load;
			default:              cmd = cmd;
		endcase
	end

	assign in_stall  = (state_q != ntc_pkg::S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ----- rtl/ntc_dp.sv -----
// ----------------------------------------------------------------------------
// NTC datapath
// Configuration registers, sample accumulator, iterative log unit, ln
// scaling multiplier, shared restoring divider and the output register.
// ----------------------------------------------------------------------------
module ntc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ntc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ntc_pkg::CFG_W-1:0]           cfg_data,
	input  logic [ntc_pkg::IN_W-1:0]            adc_sample,
	input  ntc_pkg::ntc_cmd_t                   cmd,
	output ntc_pkg::ntc_stat_t                  stat,
	output logic signed [ntc_pkg::TEMP_W-1:0]   temp_centi_c,
	output logic [1:0]                          status_code
);

	// Configuration registers.
	logic [ntc_pkg::CNT_W-1:0]          count_q;
	logic [ntc_pkg::OHM_W-1:0]          series_q, nominal_q;
	logic [ntc_pkg::CENTI_W-1:0]        nom_temp_q;
	logic [ntc_pkg::BETA_W-1:0]         beta_q;

	// Accumulator.
	logic [ntc_pkg::SUM_W-1:0]          sum_q;
	logic [ntc_pkg::CNT_W-1:0]          taken_q;

	// Log unit and ln scaling.
	logic [ntc_pkg::M_W-1:0]            m_q;
	logic [ntc_pkg::FRAC_W-1:0]         frac_q;
	logic [ntc_pkg::P_W-1:0]            pos_q;
	logic signed [ntc_pkg::L_W-1:0]     l_q;
	logic [ntc_pkg::LN_W-1:0]           lnmag_q;
	logic                               lsign_q;

	// Divider and inverse temperature.
	logic [ntc_pkg::NUM_W-1:0]          quo_q;
	logic [ntc_pkg::DEN_W-1:0]          rem_q, den_q;
	logic [ntc_pkg::X_W-1:0]            tmag_q;
	logic signed [ntc_pkg::X_W-1:0]     x_q;
	logic                               sat_q;
	ntc_pkg::status_t                   status_q;

	// Output register.
	logic signed [ntc_pkg::TEMP_W-1:0]  temp_out_q;
	logic [1:0]                         status_out_q;

	logic [ntc_pkg::CNT_W-1:0]          count_eff;
	logic [ntc_pkg::OHM_W-1:0]          series_eff, nominal_eff;
	logic [ntc_pkg::BETA_W-1:0]         beta_eff;
	logic [ntc_pkg::SUM_W-1:0]          sample_ext, top;
	logic                               sum_zero, sum_high;
	logic [ntc_pkg::LG_IN_W-1:0]        lg_op;
	logic [ntc_pkg::P_W-1:0]            lg_pos;
	logic [2*ntc_pkg::M_W-1:0]          sq;
	logic [2*ntc_pkg::M_W-ntc_pkg::LG_Q-1:0] sq_sh;
	logic [ntc_pkg::L_W-1:0]            lg_ext;
	logic [ntc_pkg::MAG_W-1:0]          l_abs;
	logic [2*ntc_pkg::MAG_W-1:0]        ln_prod;
	logic [ntc_pkg::BETA100_W-1:0]      beta100;
	logic signed [ntc_pkg::TC_W:0]      tc0_s;
	logic [ntc_pkg::TC_W-1:0]           tc0;
	logic [ntc_pkg::NUM_W-1:0]          div_num, recip_one;
	logic [ntc_pkg::DEN_W-1:0]          div_den;
	logic [ntc_pkg::DEN_W:0]            rem_sh, rem_diff;
	logic                               rem_ge;
	logic signed [ntc_pkg::X_W-1:0]     x_next, inv0;
	logic signed [ntc_pkg::TEMP_W:0]    tk_off;
	logic signed [ntc_pkg::TEMP_W-1:0]  temp_next;

	// Zero registers act as one.
	assign count_eff   = (count_q == '0) ? ntc_pkg::CNT_W'(1) : count_q;
	assign series_eff  = (series_q == '0) ? ntc_pkg::OHM_W'(1) : series_q;
	assign nominal_eff = (nominal_q == '0) ? ntc_pkg::OHM_W'(1) : nominal_q;
	assign beta_eff    = (beta_q == '0) ? ntc_pkg::BETA_W'(1) : beta_q;

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= ntc_pkg::CNT_W'(1);
			series_q   <= ntc_pkg::OHM_W'(10000);
			nominal_q  <= ntc_pkg::OHM_W'(10000);
			nom_temp_q <= ntc_pkg::CENTI_W'(2500);
			beta_q     <= ntc_pkg::BETA_W'(3950);
		end else if (cfg_we) begin
			unique case (cfg_index)
				ntc_pkg::CFG_SAMPLE_COUNT: count_q    <= cfg_data[ntc_pkg::CNT_W-1:0];
				ntc_pkg::CFG_SERIES_OHMS:  series_q   <= cfg_data[ntc_pkg::OHM_W-1:0];
				ntc_pkg::CFG_NOMINAL_OHMS: nominal_q  <= cfg_data[ntc_pkg::OHM_W-1:0];
				ntc_pkg::CFG_NOMINAL_TEMP: nom_temp_q <= cfg_data[ntc_pkg::CENTI_W-1:0];
				ntc_pkg::CFG_BETA:         beta_q     <= cfg_data[ntc_pkg::BETA_W-1:0];
				default:                   count_q    <= count_q;
			endcase
		end
	end

	// Sample accumulator, cleared when a round's result is loaded into the output register.
	assign sample_ext = ntc_pkg::SUM_W'(adc_sample) & ntc_pkg::FULL;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			taken_q <= '0;
		end else if (cmd.out_load) begin
			sum_q   <= '0;
			taken_q <= '0;
		end else if (cmd.acc_en) begin
			sum_q   <= sum_q + sample_ext;
			taken_q <= taken_q + 1'b1;
		end
	end

	// Round checks against full scale times the samples taken.
	assign top      = ntc_pkg::FULL * ntc_pkg::SUM_W'(taken_q);
	assign sum_zero = (sum_q == '0);
	assign sum_high = (sum_q >= top);
	assign stat.round_full = (taken_q >= count_eff);
	assign stat.special    = sum_zero || sum_high;

	// Log operand select and leading-one position.
	always_comb begin
		unique case (cmd.lg_sel)
			2'd0:    lg_op = ntc_pkg::LG_IN_W'(series_eff);
			2'd1:    lg_op = ntc_pkg::LG_IN_W'(top - sum_q);
			2'd2:    lg_op = ntc_pkg::LG_IN_W'(sum_q);
			default: lg_op = ntc_pkg::LG_IN_W'(nominal_eff);
		endcase
		lg_pos = '0;
		for (int i = 0; i < ntc_pkg::LG_IN_W; i++) begin
			if (lg_op[i]) lg_pos = ntc_pkg::P_W'(i);
		end
	end

	// One squaring per cycle yields one fraction bit.
	assign sq     = (2*ntc_pkg::M_W)'(m_q) * (2*ntc_pkg::M_W)'(m_q);
	assign sq_sh  = sq[2*ntc_pkg::M_W-1:ntc_pkg::LG_Q];
	assign lg_ext = ntc_pkg::L_W'({pos_q, frac_q});

	// ln magnitude: |L| times ln 2 in Q30, rounded.
	assign l_abs   = l_q[ntc_pkg::L_W-1] ? ntc_pkg::MAG_W'(-l_q) : ntc_pkg::MAG_W'(l_q);
	assign ln_prod = (2*ntc_pkg::MAG_W)'(l_abs) * (2*ntc_pkg::MAG_W)'(ntc_pkg::LN2_Q30);

	always_ff @(posedge clk) begin
		if (cmd.lg_load) begin
			m_q    <= ntc_pkg::M_W'(lg_op) << (ntc_pkg::P_W'(ntc_pkg::LG_Q) - lg_pos);
			frac_q <= '0;
			pos_q  <= lg_pos;
		end else if (cmd.lg_step) begin
			if (sq_sh[ntc_pkg::M_W]) begin
				m_q    <= sq_sh[ntc_pkg::M_W:1];
				frac_q <= {frac_q[ntc_pkg::FRAC_W-2:0], 1'b1};
			end else begin
				m_q    <= sq_sh[ntc_pkg::M_W-1:0];
				frac_q <= {frac_q[ntc_pkg::FRAC_W-2:0], 1'b0};
			end
		end
		if (cmd.check) begin
			l_q <= '0;
		end else if (cmd.l_add) begin
			l_q <= cmd.lg_sel[1] ? l_q - $signed(lg_ext) : l_q + $signed(lg_ext);
		end
		if (cmd.ln_mul) begin
			lnmag_q <= ntc_pkg::LN_W'((ln_prod + ((2*ntc_pkg::MAG_W)'(1) << 29)) >> 30);
			lsign_q <= l_q[ntc_pkg::L_W-1];
		end
	end

	// Divider operands: beta term, inverse nominal temperature, final reciprocal.
	assign beta100   = ntc_pkg::BETA100_W'(beta_eff) * ntc_pkg::BETA100_W'(100);
	assign tc0_s     = $signed({{2{nom_temp_q[ntc_pkg::CENTI_W-1]}}, nom_temp_q})
	                   + (ntc_pkg::TC_W+1)'(ntc_pkg::KELVIN_CENTI);
	assign tc0       = tc0_s[ntc_pkg::TC_W-1:0];
	assign recip_one = ntc_pkg::NUM_W'(1) << ntc_pkg::RECIP_SHIFT;

	always_comb begin
		unique case (cmd.div_sel)
			ntc_pkg::DIV_TERM: begin
				div_num = {lnmag_q, ntc_pkg::FRAC_W'(0), 1'b0} >> 1;
				div_num = div_num + ntc_pkg::NUM_W'(beta100 >> 1);
				div_den = ntc_pkg::DEN_W'(beta100);
			end
			ntc_pkg::DIV_INV0: begin
				div_num = recip_one + ntc_pkg::NUM_W'(tc0 >> 1);
				div_den = ntc_pkg::DEN_W'(tc0);
			end
			default: begin
				div_num = recip_one + ntc_pkg::NUM_W'(x_q[ntc_pkg::DEN_W-1:0] >> 1);
				div_den = x_q[ntc_pkg::DEN_W-1:0];
			end
		endcase
	end

	// Restoring division step: one quotient bit per cycle.
	assign rem_sh   = {rem_q, quo_q[ntc_pkg::NUM_W-1]};
	assign rem_diff = rem_sh - {1'b0, den_q};
	assign rem_ge   = (rem_sh >= {1'b0, den_q});

	// Inverse temperature sum; the term sign follows the log sum.
	assign inv0   = $signed(quo_q[ntc_pkg::X_W-1:0]);
	assign x_next = lsign_q ? inv0 - $signed(tmag_q) : inv0 + $signed(tmag_q);
	assign stat.x_nonpos = x_next[ntc_pkg::X_W-1] || (x_next == '0);

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			quo_q <= div_num;
			rem_q <= '0;
			den_q <= div_den;
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[ntc_pkg::NUM_W-2:0], rem_ge};
			rem_q <= rem_ge ? rem_diff[ntc_pkg::DEN_W-1:0] : rem_sh[ntc_pkg::DEN_W-1:0];
		end
		if (cmd.div_load && (cmd.div_sel == ntc_pkg::DIV_INV0)) begin
			tmag_q <= quo_q[ntc_pkg::X_W-1:0];
		end
		if (cmd.check) begin
			sat_q <= 1'b0;
			if (sum_zero) status_q <= ntc_pkg::STATUS_ZERO;
			else if (sum_high) status_q <= ntc_pkg::STATUS_FULL;
			else status_q <= ntc_pkg::STATUS_OK;
		end else if (cmd.x_calc) begin
			x_q   <= x_next;
			sat_q <= stat.x_nonpos;
		end
	end

	// Final temperature with clamping.
	assign tk_off = $signed({1'b0, quo_q[ntc_pkg::TEMP_W-1:0]})
	                - (ntc_pkg::TEMP_W+1)'(ntc_pkg::KELVIN_CENTI);
	always_comb begin
		if (status_q != ntc_pkg::STATUS_OK)
			temp_next = '0;
		else if (sat_q || (quo_q > ntc_pkg::NUM_W'(ntc_pkg::TK_MAX)))
			temp_next = ntc_pkg::TEMP_W'(ntc_pkg::TEMP_MAX);
		else
			temp_next = tk_off[ntc_pkg::TEMP_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			temp_out_q   <= temp_next;
			status_out_q <= status_q;
		end
	end

	assign temp_centi_c = temp_out_q;
	assign status_code  = status_out_q;

endmodule

// ----- rtl/ntc_checker.sv -----
// ----------------------------------------------------------------------------
// NTC port checker
// Watches the top-level ports for output holding and result consistency.
// ----------------------------------------------------------------------------
module ntc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [ntc_pkg::TEMP_W-1:0]  temp_centi_c,
	input logic [1:0]                         status_code
);

	// A stalled result holds until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(temp_centi_c) && $stable(status_code))
		else $error("stalled result changed");

	// Each accepted sample is followed by a count check, during which input stalls.
	a_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("sample accepted without a check cycle");

	// Error results carry a zero temperature.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status_code != 2'd0) |-> (temp_centi_c == '0))
		else $error("error result with nonzero temperature");

	// Status codes stay within their defined set.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status_code != 2'd3))
		else $error("undefined status code");

	// A valid temperature never lies below absolute zero.
	a_temp_floor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status_code == 2'd0) |->
			(temp_centi_c >= -(ntc_pkg::KELVIN_CENTI)))
		else $error("temperature below absolute zero");

endmodule

bind ntc_beta_temperature_core ntc_checker u_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NTC Beta-equation temperature core testbench
// Drives ADC samples and register writes under several idling patterns,
// predicts every temperature result in fixed point and compares each result
// transfer field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb;

	typedef longint unsigned u64_t;

	localparam logic [ntc_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;
	localparam int  DRAIN_CYCLES = 300;
	localparam longint CYCLE_LIMIT = 4000000;
	localparam u64_t ONE48 = 64'd1 << 48;

	typedef struct {
		logic [ntc_pkg::TEMP_W-1:0] temp;
		ntc_pkg::status_t           status;
	} temp_result_t;

	typedef struct {
		bit                            is_cfg;
		logic [ntc_pkg::CFG_IDX_W-1:0] idx;
		logic [ntc_pkg::CFG_W-1:0]     data;
		logic [ntc_pkg::IN_W-1:0]      sample;
		bit                            typed;
		logic [ntc_pkg::TEMP_W-1:0]    temp;
		ntc_pkg::status_t              status;
	} stim_row_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [ntc_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [ntc_pkg::CFG_W-1:0]           cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	logic [ntc_pkg::IN_W-1:0]            adc_sample = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic signed [ntc_pkg::TEMP_W-1:0]   temp_centi_c;
	logic [1:0]                          status_code;

	// Predictor copy of the configuration and the accumulator.
	logic [8:0]          cnt_reg;
	logic [19:0]         rs_reg;
	logic [19:0]         r0_reg;
	logic signed [14:0]  t0_reg;
	logic [13:0]         beta_reg;
	u64_t                acc_sum;
	u64_t                acc_taken;

	temp_result_t pending_temps[$];
	stim_row_t    rows[$];
	int           send_idle_pct = 0;
	int           stall_pct = 0;
	bit           failed = 1'b0;
	longint       cycles = 0;

	ntc_beta_temperature_core u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Base-2 logarithm in Q24 by repeated squaring of a Q30 mantissa.
	function automatic longint lg2_q24(u64_t x);
		int p;
		u64_t m;
		u64_t frac;
		frac = 0;
		if (x == 0) x = 1;
		p = 63;
		while (x[p] == 1'b0) p--;
		m = (p > 30) ? (x >> (p - 30)) : (x << (30 - p));
		for (int i = 0; i < 24; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		return longint'((u64_t'(p) << 24) | frac);
	endfunction

	function automatic u64_t nonzero(u64_t v);
		return (v == 0) ? 1 : v;
	endfunction

	task automatic apply_reg(logic [ntc_pkg::CFG_IDX_W-1:0] idx, logic [ntc_pkg::CFG_W-1:0] d);
		case (idx)
			ntc_pkg::CFG_SAMPLE_COUNT: cnt_reg = d[8:0];
			ntc_pkg::CFG_SERIES_OHMS:  rs_reg = d[19:0];
			ntc_pkg::CFG_NOMINAL_OHMS: r0_reg = d[19:0];
			ntc_pkg::CFG_NOMINAL_TEMP: t0_reg = d[14:0];
			ntc_pkg::CFG_BETA:         beta_reg = d[13:0];
			default: ;
		endcase
	endtask

	// Accumulate one sample; returns 1 and the temperature when a round closes.
	function automatic bit accumulate_sample(logic [ntc_pkg::IN_W-1:0] s,
			output temp_result_t r);
		u64_t top, lnmag, tmag, beta100, tc0, tk, mag;
		longint lval, inv0, x, t;
		acc_sum += s;
		acc_taken++;
		r.temp = '0;
		r.status = ntc_pkg::STATUS_OK;
		if (acc_taken < nonzero(cnt_reg)) return 1'b0;
		top = 4095 * acc_taken;
		t = 0;
		if (acc_sum == 0) begin
			r.status = ntc_pkg::STATUS_ZERO;
		end else if (acc_sum >= top) begin
			r.status = ntc_pkg::STATUS_FULL;
		end else begin
			lval = lg2_q24(nonzero(rs_reg)) + lg2_q24(top - acc_sum)
				- lg2_q24(acc_sum) - lg2_q24(nonzero(r0_reg));
			mag = (lval < 0) ? u64_t'(-lval) : u64_t'(lval);
			lnmag = (mag * 64'd744261118 + (64'd1 << 29)) >> 30;
			beta100 = 100 * nonzero(beta_reg);
			tmag = ((lnmag << 24) + beta100 / 2) / beta100;
			tc0 = u64_t'(longint'(t0_reg) + ntc_pkg::KELVIN_CENTI);
			inv0 = longint'((ONE48 + tc0 / 2) / tc0);
			x = (lval < 0) ? inv0 - longint'(tmag) : inv0 + longint'(tmag);
			if (x <= 0) begin
				t = ntc_pkg::TEMP_MAX;
			end else begin
				tk = (ONE48 + u64_t'(x) / 2) / u64_t'(x);
				t = (tk > ntc_pkg::TK_MAX) ? ntc_pkg::TEMP_MAX :
					longint'(tk) - ntc_pkg::KELVIN_CENTI;
			end
		end
		r.temp = t[ntc_pkg::TEMP_W-1:0];
		acc_sum = 0;
		acc_taken = 0;
		return 1'b1;
	endfunction

	// Wait until every predicted result has arrived and the core has settled.
	task automatic drain();
		wait (pending_temps.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [ntc_pkg::CFG_IDX_W-1:0] idx, logic [ntc_pkg::CFG_W-1:0] d);
		drain();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = d;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, d);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// One sample transfer with random idle cycles ahead of it.
	task automatic send_sample(logic [ntc_pkg::IN_W-1:0] s, bit typed, temp_result_t typed_r);
		temp_result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		adc_sample = s;
		do @(posedge clk); while (in_stall);
		if (accumulate_sample(s, r)) pending_temps.push_back(typed ? typed_r : r);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic add_row(bit c, logic [ntc_pkg::CFG_IDX_W-1:0] i,
			logic [ntc_pkg::CFG_W-1:0] d, logic [ntc_pkg::IN_W-1:0] s, bit ty,
			logic [ntc_pkg::TEMP_W-1:0] t, ntc_pkg::status_t st);
		stim_row_t r;
		r.is_cfg = c; r.idx = i; r.data = d; r.sample = s;
		r.typed = ty; r.temp = t; r.status = st;
		rows.push_back(r);
	endtask

	function automatic logic [ntc_pkg::IN_W-1:0] rand_sample();
		case ($urandom_range(9))
			0: return '0;
			1: return 12'hFFF;
			2: return 12'(2048 + $urandom_range(64) - 32);
			3: return 12'($urandom_range(15));
			4: return 12'(4095 - $urandom_range(15));
			default: return 12'($urandom);
		endcase
	endfunction

	task automatic rand_config();
		int k;
		k = $urandom_range(99);
		write_reg(ntc_pkg::CFG_SAMPLE_COUNT, (k < 70) ? 20'($urandom_range(4)) :
			(k < 96) ? 20'($urandom_range(16, 5)) : 20'd256);
		write_reg(ntc_pkg::CFG_SERIES_OHMS, ($urandom_range(4) == 0) ?
			(($urandom_range(1)) ? 20'd1 : 20'd1000000) : 20'($urandom));
		write_reg(ntc_pkg::CFG_NOMINAL_OHMS, ($urandom_range(4) == 0) ?
			(($urandom_range(1)) ? 20'd1 : 20'hFFFFF) : 20'($urandom_range(200000, 100)));
		write_reg(ntc_pkg::CFG_NOMINAL_TEMP, ($urandom_range(3) == 0) ? 20'($urandom) :
			20'(15'($urandom_range(15000, 0) - 4000)));
		write_reg(ntc_pkg::CFG_BETA, ($urandom_range(4) == 0) ? 20'($urandom) :
			20'($urandom_range(5000, 2000)));
		if ($urandom_range(3) == 0) write_reg(3'($urandom_range(7, 5)), 20'($urandom));
	endtask

	// Receiver back-pressure.
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// Compare each result transfer against the oldest prediction.
	always @(posedge clk) begin
		temp_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_temps.size() == 0) begin
				$display("%0t: unexpected result temp=%0d status=%0d", $time,
					temp_centi_c, status_code);
				failed = 1'b1;
			end else begin
				e = pending_temps.pop_front();
				if (temp_centi_c !== e.temp) begin
					$display("%0t: temp_centi_c expected %0d actual %0d", $time,
						$signed(e.temp), temp_centi_c);
					failed = 1'b1;
				end
				if (status_code !== e.status) begin
					$display("%0t: status_code expected %0d actual %0d", $time,
						e.status, status_code);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		temp_result_t tr;
		cnt_reg = 9'd1; rs_reg = 20'd10000; r0_reg = 20'd10000;
		t0_reg = 15'sd2500; beta_reg = 14'd3950;
		acc_sum = 0; acc_taken = 0;

		// Directed rows: extremes, zero registers, unused index, count changes.
		add_row(0, 0, 0, 12'd0, 1, '0, ntc_pkg::STATUS_ZERO);
		add_row(0, 0, 0, 12'hFFF, 1, '0, ntc_pkg::STATUS_FULL);
		add_row(0, 0, 0, 12'd1, 0, '0, ntc_pkg::STATUS_OK);
		add_row(0, 0, 0, 12'd4094, 0, '0, ntc_pkg::STATUS_OK);
		add_row(0, 0, 0, 12'd2048, 0, '0, ntc_pkg::STATUS_OK);
		add_row(1, ntc_pkg::CFG_BETA, 20'd1, 0, 0, '0, ntc_pkg::STATUS_OK);
		add_row(0, 0, 0, 12'd4094, 0, '0, ntc_pkg::STATUS_OK);
		add_row(0, 0, 0, 12'd1, 0, '0, ntc_pkg::STATUS_OK);
		add_row(1, ntc_pkg::CFG_BETA, 20'd0, 0, 0, '0, ntc_pkg::STATUS_OK);
		add_row(0, 0, 0, 12'd100, 0, '0, ntc_pkg::STATUS_OK);
		add_row(1, ntc_pkg::CFG_SERIES_OHMS, 20'd0, 0, 0, '0, ntc_pkg::STATUS_OK);
		add_row(1, ntc_pkg::CFG_NOMINAL_OHMS, 20'd0, 0, 0, '0, ntc_pkg::STATUS_OK);
		add_row(0, 0, 0, 12'd2000, 0, '0, ntc_pkg::STATUS_OK);
		add_row(1, ntc_pkg::CFG_SERIES_OHMS, 20'd1000000, 0, 0, '0, ntc_pkg::STATUS_OK);
		add_row(1, ntc_pkg::CFG_NOMINAL_OHMS, 20'd1, 0, 0, '0, ntc_pkg::STATUS_OK);
		add_row(1, ntc_pkg::CFG_NOMINAL_TEMP, 20'(15'h7FFF & -4000), 0, 0, '0,
			ntc_pkg::STATUS_OK);
		add_row(1, ntc_pkg::CFG_BETA, 20'd10000, 0, 0, '0, ntc_pkg::STATUS_OK);
		add_row(0, 0, 0, 12'd1, 0, '0, ntc_pkg::STATUS_OK);
		add_row(0, 0, 0, 12'd4094, 0, '0, ntc_pkg::STATUS_OK);
		add_row(1, ntc_pkg::CFG_NOMINAL_TEMP, 20'd15000, 0, 0, '0, ntc_pkg::STATUS_OK);
		add_row(0, 0, 0, 12'd3000, 0, '0, ntc_pkg::STATUS_OK);
		add_row(1, CFG_UNUSED, 20'hFFFFF, 0, 0, '0, ntc_pkg::STATUS_OK);
		add_row(1, ntc_pkg::CFG_SAMPLE_COUNT, 20'd0, 0, 0, '0, ntc_pkg::STATUS_OK);
		add_row(0, 0, 0, 12'd0, 1, '0, ntc_pkg::STATUS_ZERO);
		add_row(1, ntc_pkg::CFG_SAMPLE_COUNT, 20'd3, 0, 0, '0, ntc_pkg::STATUS_OK);
		add_row(0, 0, 0, 12'hFFF, 0, '0, ntc_pkg::STATUS_OK);
		add_row(1, ntc_pkg::CFG_SAMPLE_COUNT, 20'd2, 0, 0, '0, ntc_pkg::STATUS_OK);
		add_row(0, 0, 0, 12'hFFF, 1, '0, ntc_pkg::STATUS_FULL);

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				write_reg(rows[i].idx, rows[i].data);
			end else begin
				tr.temp = rows[i].temp;
				tr.status = rows[i].status;
				send_sample(rows[i].sample, rows[i].typed, tr);
			end
		end

		// Random part: four idling patterns, several settings each.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 64; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 64; end
				default: begin send_idle_pct = 16; stall_pct = 16; end
			endcase
			for (int st = 0; st < 6; st++) begin
				rand_config();
				for (int n = 0; n < 79; n++)
					send_sample(rand_sample(), 1'b0, tr);
			end
		end

		send_idle_pct = 0;
		stall_pct = 0;
		drain();
		if (!failed)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/ntc_pkg.sv
rtl/ntc_ctrl.sv
rtl/ntc_dp.sv
rtl/ntc_beta_temperature_core.sv
rtl/ntc_checker.sv
tb/tb.sv
